FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-high reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous active-high reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dclc_pkg.sv
// ----------------------------------------------------------------------------
// Depth cell level classifier package
// Widths, register map, reset values and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dclc_pkg;

   localparam int MAX_LEVELS    = 16;
   localparam int COLUMN_PIXELS = 256;

   localparam int DEPTH_W  = 16;
   localparam int DESK_W   = 14;
   localparam int SIDE_W   = 10;
   localparam int MARGIN_W = 10;
   localparam int TOP_W    = 4;
   localparam int THR_W    = 17;
   localparam int HIST_W   = 17;
   localparam int HEIGHT_W = 17;
   localparam int CLEVEL_W = 4;

   localparam int LEVEL_W = $clog2(MAX_LEVELS);
   localparam int COUNT_W = $clog2(COLUMN_PIXELS + 1);
   localparam int SUM_W   = DEPTH_W + $clog2(COLUMN_PIXELS);
   localparam int DIV_W   = (COUNT_W > SIDE_W) ? COUNT_W : SIDE_W;
   localparam int STEP_W  = $clog2(SUM_W);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_DESK_DEPTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIDE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_MARGIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_LEVEL       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd4;

   localparam logic [DESK_W-1:0]   DESK_RESET   = 14'd1000;
   localparam logic [SIDE_W-1:0]   SIDE_RESET   = 10'd50;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd20;
   localparam logic [TOP_W-1:0]    TOP_RESET    = 4'd5;
   localparam logic [THR_W-1:0]    THR_RESET    = 17'd1500;

   localparam logic KIND_COLUMN = 1'b0;
   localparam logic KIND_CELL   = 1'b1;

   localparam int RSP_DATA_W = 24;

   typedef logic [HIST_W-1:0] hist_type;

   localparam hist_type HIST_MAX = '1;

endpackage

`default_nettype wire

FILE: hw/rtl/depth_cell_level_classifier.sv
// Busy time: a request holds the block until it returns to idle, whether it gets no level,
// level zero from a small negative height or a level through the divider. A column end may
// add the column mean division before its result is loaded, and a cell end the level search.
// No new request is taken until the last is through; the shared 24-step restoring divider
// serves level and column mean, and a result waiting for rsp_tready holds the block longer.
// Reset clears the sequencer, column sums, histogram and output valid, and loads defaults.
// ----------------------------------------------------------------------------
// Depth cell level classifier
// Column heights and per-cell stack level from a stream of depth pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_cell_level_classifier (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [dclc_pkg::DEPTH_W-1:0]       req_tdata,  // depth
   input  wire                                req_tlast,  // column_end
   input  wire                                req_tuser,  // cell_end
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [dclc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // column_height, cell_level
   output logic                               rsp_tlast,  // last
   output logic                               rsp_tuser,  // result_kind
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [dclc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [dclc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dclc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LEVEL   = 3'd1;
   localparam logic [2:0] S_DIV     = 3'd2;
   localparam logic [2:0] S_COUNT   = 3'd3;
   localparam logic [2:0] S_COLUMN  = 3'd4;
   localparam logic [2:0] S_COLOUT  = 3'd5;
   localparam logic [2:0] S_SEARCH  = 3'd6;
   localparam logic [2:0] S_CELLOUT = 3'd7;

   localparam int SW = dclc_pkg::SUM_W;
   localparam int DW = dclc_pkg::DIV_W;
   localparam int LW = dclc_pkg::LEVEL_W;

   logic [dclc_pkg::DESK_W-1:0]   desk_ff, desk_in;
   logic [dclc_pkg::SIDE_W-1:0]   side_ff, side_in;
   logic [dclc_pkg::MARGIN_W-1:0] margin_ff, margin_in;
   logic [dclc_pkg::TOP_W-1:0]    top_ff, top_in;
   logic [dclc_pkg::THR_W-1:0]    thr_ff, thr_in;

   logic [2:0]                    state_ff, state_in;
   logic [dclc_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic                          col_end_ff, col_end_in;
   logic                          cell_end_ff, cell_end_in;
   logic [SW-1:0]                 sum_ff, sum_in;
   logic [dclc_pkg::COUNT_W-1:0]  count_ff, count_in;
   dclc_pkg::hist_type            hist_ff [dclc_pkg::MAX_LEVELS];
   dclc_pkg::hist_type            hist_in [dclc_pkg::MAX_LEVELS];
   logic [LW-1:0]                 idx_ff, idx_in;
   logic [LW-1:0]                 found_ff, found_in;

   logic [SW-1:0]                 quo_ff, quo_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   logic [DW-1:0]                 dvs_ff, dvs_in;
   logic [dclc_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          div_col_ff, div_col_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dclc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_kind_ff, rsp_kind_in;

   logic                          accept;
   logic                          csr_write;
   logic [dclc_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                          out_free;
   logic [dclc_pkg::SIDE_W-1:0]   side_eff;
   logic [17:0]                   hei;
   logic [17:0]                   hei_mag;
   logic                          level_ok;
   logic [DW+1:0]                 diff;
   logic                          ge;
   logic [dclc_pkg::HEIGHT_W-1:0] height;
   logic                          hit;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[dclc_pkg::CSR_ADDR_W-1:2];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign side_eff = (side_ff == '0) ? dclc_pkg::SIDE_W'(1) : side_ff;
   assign hei      = 18'({4'b0, desk_ff}) - 18'({2'b0, depth_ff})
                   + 18'(side_eff >> 1);
   assign hei_mag  = 18'(0) - hei;
   assign level_ok = (depth_ff != '0)
                   && (17'(depth_ff) <= 17'(desk_ff) + 17'(margin_ff));

   assign diff = {1'b0, rem_ff, quo_ff[SW-1]} - {2'b0, dvs_ff};
   assign ge   = !diff[DW+1];

   assign height = dclc_pkg::HEIGHT_W'(desk_ff) - quo_ff[dclc_pkg::HEIGHT_W-1:0];
   assign hit    = hist_ff[idx_ff] > dclc_pkg::hist_type'(thr_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;

   always_comb begin
      unique case (csr_idx)
         dclc_pkg::REG_DESK_DEPTH:      csr_prdata = 32'(desk_ff);
         dclc_pkg::REG_BLOCK_SIDE:      csr_prdata = 32'(side_ff);
         dclc_pkg::REG_ERROR_MARGIN:    csr_prdata = 32'(margin_ff);
         dclc_pkg::REG_TOP_LEVEL:       csr_prdata = 32'(top_ff);
         dclc_pkg::REG_COUNT_THRESHOLD: csr_prdata = 32'(thr_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   always_comb begin
      desk_in   = desk_ff;
      side_in   = side_ff;
      margin_in = margin_ff;
      top_in    = top_ff;
      thr_in    = thr_ff;
      if (csr_write) begin
         unique case (csr_idx)
            dclc_pkg::REG_DESK_DEPTH:   desk_in = csr_pwdata[dclc_pkg::DESK_W-1:0];
            dclc_pkg::REG_BLOCK_SIDE:   side_in = csr_pwdata[dclc_pkg::SIDE_W-1:0];
            dclc_pkg::REG_ERROR_MARGIN: margin_in = csr_pwdata[dclc_pkg::MARGIN_W-1:0];
            dclc_pkg::REG_TOP_LEVEL:    top_in = csr_pwdata[dclc_pkg::TOP_W-1:0];
            dclc_pkg::REG_COUNT_THRESHOLD: begin
               thr_in = csr_pwdata[dclc_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      col_end_in  = col_end_ff;
      cell_end_in = cell_end_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      hist_in     = hist_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      step_in     = step_ff;
      div_col_in  = div_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_kind_in  = rsp_kind_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               depth_in    = req_tdata;
               col_end_in  = req_tlast || req_tuser;
               cell_end_in = req_tuser;
               if ((req_tdata != '0)
                     && (count_ff < dclc_pkg::COUNT_W'(dclc_pkg::COLUMN_PIXELS))) begin
                  sum_in   = sum_ff + SW'(req_tdata);
                  count_in = count_ff + 1'b1;
               end
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (!level_ok) begin
               state_in = S_COLUMN;
            end else if (hei[17]) begin
               if (hei_mag < 18'(side_eff)) begin
                  idx_in   = '0;
                  state_in = S_COUNT;
               end else begin
                  state_in = S_COLUMN;
               end
            end else begin
               quo_in     = SW'(hei[16:0]);
               rem_in     = '0;
               dvs_in     = DW'(side_eff);
               step_in    = dclc_pkg::STEP_W'(SW - 1);
               div_col_in = 1'b0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? diff[DW-1:0] : {rem_ff[DW-2:0], quo_ff[SW-1]};
            quo_in  = {quo_ff[SW-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (div_col_ff) begin
                  state_in = S_COLOUT;
               end else if ((quo_in <= SW'(top_ff))
                     && (quo_in < SW'(dclc_pkg::MAX_LEVELS))) begin
                  idx_in   = quo_in[LW-1:0];
                  state_in = S_COUNT;
               end else begin
                  state_in = S_COLUMN;
               end
            end
         end
         S_COUNT: begin
            if (hist_ff[idx_ff] != dclc_pkg::HIST_MAX) begin
               hist_in[idx_ff] = hist_ff[idx_ff] + 1'b1;
            end
            state_in = S_COLUMN;
         end
         S_COLUMN: begin
            if (!col_end_ff) begin
               state_in = S_IDLE;
            end else begin
               sum_in   = '0;
               count_in = '0;
               if (count_ff == '0) begin
                  quo_in   = '0;
                  state_in = S_COLOUT;
               end else begin
                  quo_in     = sum_ff;
                  rem_in     = '0;
                  dvs_in     = DW'(count_ff);
                  step_in    = dclc_pkg::STEP_W'(SW - 1);
                  div_col_in = 1'b1;
                  state_in   = S_DIV;
               end
            end
         end
         S_COLOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dclc_pkg::KIND_COLUMN;
               rsp_last_in  = !cell_end_ff;
               rsp_data_in  = dclc_pkg::RSP_DATA_W'(height);
               idx_in       = '0;
               state_in     = cell_end_ff ? S_SEARCH : S_IDLE;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               found_in = idx_ff;
               state_in = S_CELLOUT;
            end else if ((dclc_pkg::TOP_W'(idx_ff) == top_ff)
                  || (idx_ff == LW'(dclc_pkg::MAX_LEVELS - 1))) begin
               found_in = '0;
               state_in = S_CELLOUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CELLOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dclc_pkg::KIND_CELL;
               rsp_last_in  = 1'b1;
               rsp_data_in  = dclc_pkg::RSP_DATA_W'(
                  {dclc_pkg::CLEVEL_W'(found_ff), {dclc_pkg::HEIGHT_W{1'b0}}});
               for (int i = 0; i < dclc_pkg::MAX_LEVELS; i++) begin
                  hist_in[i] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desk_ff      <= dclc_pkg::DESK_RESET;
         side_ff      <= dclc_pkg::SIDE_RESET;
         margin_ff    <= dclc_pkg::MARGIN_RESET;
         top_ff       <= dclc_pkg::TOP_RESET;
         thr_ff       <= dclc_pkg::THR_RESET;
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < dclc_pkg::MAX_LEVELS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         desk_ff      <= desk_in;
         side_ff      <= side_in;
         margin_ff    <= margin_in;
         top_ff       <= top_in;
         thr_ff       <= thr_in;
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff    <= depth_in;
      col_end_ff  <= col_end_in;
      cell_end_ff <= cell_end_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      step_ff     <= step_in;
      div_col_ff  <= div_col_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_kind_ff <= rsp_kind_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dclc_checker.sv
// ----------------------------------------------------------------------------
// Depth cell level classifier checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dclc_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [dclc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                             rsp_tlast,
   input wire                             rsp_tuser
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready,
      "ready right after an accepted request")

   `ASSERT_IMPLIES(a_cell_last, clock, reset,
      rsp_tvalid && (rsp_tuser == dclc_pkg::KIND_CELL), rsp_tlast,
      "cell result not marked last")

   `ASSERT_IMPLIES(a_cell_fields, clock, reset,
      rsp_tvalid && (rsp_tuser == dclc_pkg::KIND_CELL),
      rsp_tdata[16:0] == '0 && rsp_tdata[23:21] == '0, "cell result carries stray bits")

   `ASSERT_IMPLIES(a_column_fields, clock, reset,
      rsp_tvalid && (rsp_tuser == dclc_pkg::KIND_COLUMN),
      rsp_tdata[23:17] == '0, "column result carries a level")

endmodule

bind depth_cell_level_classifier dclc_checker u_dclc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
